[hw/rtl/csvtok_pkg.sv]
// ----------------------------------------------------------------------------
// csvtok_pkg: shared types and constants of the csv byte tokenizer
// Payload structs, result kinds, parser modes and sequencer states.
// ----------------------------------------------------------------------------
package csvtok_pkg;

   // held whitespace buffer
   localparam int HOLD_DEPTH = 32;
   localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [HOLD_AW-1:0] addr_type;

   // byte constants
   localparam logic [7:0] SEP_RESET = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] BOM_B0    = 8'hEF;
   localparam logic [7:0] BOM_B1    = 8'hBB;
   localparam logic [7:0] BOM_B2    = 8'hBF;

   // result kinds
   typedef enum logic [2:0] {
      K_CONTENT = 3'd0,
      K_FIELD   = 3'd1,
      K_ROW     = 3'd2,
      K_BADQ    = 3'd3,
      K_UNTERM  = 3'd4,
      K_OVER    = 3'd5
   } out_kind_type;

   // parser modes
   typedef enum logic [2:0] {
      M_LINE   = 3'd0,
      M_HOLD   = 3'd1,
      M_FSTART = 3'd2,
      M_PLAIN  = 3'd3,
      M_QUOTED = 3'd4,
      M_QSEEN  = 3'd5,
      M_AFTERQ = 3'd6
   } mode_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_BOM,
      S_REPLAY,
      S_ROW,
      S_FIN,
      S_ENDROW,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      out_kind_type out_kind;
      logic [7:0]   out_byte;
      logic         last_of_run;
   } rsp_type;

   // classification of the byte under test
   typedef struct packed {
      logic is_sep;
      logic is_quote;
      logic is_lf;
      logic is_cr;
      logic is_ws;
   } byte_class_type;

   // utf-8 byte order mark, byte by position
   function automatic logic [7:0] bom_byte(input logic [1:0] pos);
      logic [7:0] b;
      b = BOM_B0;
      case (pos)
         2'd0:    b = BOM_B0;
         2'd1:    b = BOM_B1;
         2'd2:    b = BOM_B2;
         default: b = BOM_B0;
      endcase
      return b;
   endfunction

endpackage

[hw/rtl/csvtok_ram.sv]
// ----------------------------------------------------------------------------
// csvtok_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module csvtok_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[hw/rtl/csv_byte_tokenizer.sv]
// ----------------------------------------------------------------------------
// csv_byte_tokenizer: streaming csv tokenizer
// Takes one text byte per transfer and returns content bytes, field ends and
// row ends, one result per output transfer, with last_of_run on the final
// result of each byte. A byte steps through a small sequencer (accept,
// decode, a row step where needed, final check, retire), plus a step for each
// released byte order mark byte or replayed held whitespace byte and one when
// the final byte closes a row; it also waits while a result cannot be handed
// on. A result goes to the output when the next one forms or the byte
// retires. Leading whitespace of a line is kept in a 32 entry RAM and
// replayed through the same byte classifier once the line holds real text.
// The separator register may be written only while no byte is in flight.
// ----------------------------------------------------------------------------
module csv_byte_tokenizer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  csvtok_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output csvtok_pkg::rsp_type  rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_field_separator
);

   csvtok_pkg::seq_state_type  state_ff, state_in;
   csvtok_pkg::mode_type       mode_ff, mode_in;
   csvtok_pkg::cnt_type        cnt_ff, cnt_in, hcnt;
   csvtok_pkg::cnt_type        idx_ff, idx_in;
   logic [1:0]                 bom_ff, bom_in;
   logic                       cr_ff, cr_in;
   logic                       row_seen_ff, row_seen_in;
   logic                       err_ff, err_in;
   logic                       in_fin_ff, in_fin_in;
   logic [7:0]                 sep_ff;
   logic [7:0]                 byte_ff;
   logic                       fin_ff;

   logic                       pend_valid_ff;
   csvtok_pkg::out_kind_type   pend_kind_ff;
   logic [7:0]                 pend_byte_ff;
   logic                       rsp_valid_ff;
   csvtok_pkg::rsp_type        rsp_ff;

   logic                       emit_valid;
   csvtok_pkg::out_kind_type   emit_kind;
   logic [7:0]                 emit_byte;
   logic                       wr_en;
   logic [7:0]                 rd_data;
   logic [7:0]                 cls_src;
   csvtok_pkg::byte_class_type cls;
   logic                       slot_free;
   logic                       advance;
   logic                       accept;
   logic                       push;
   logic                       bom_hit;
   logic                       bom_last;
   logic                       replay_last;

   // handshakes
   assign req_stall = (state_ff != csvtok_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign advance   = (state_ff == csvtok_pkg::S_IDLE) || slot_free;

   // shared byte classifier: replayed byte or the current byte
   assign cls_src      = (state_ff == csvtok_pkg::S_REPLAY) ? rd_data : byte_ff;
   assign cls.is_sep   = (cls_src == sep_ff);
   assign cls.is_quote = (cls_src == csvtok_pkg::CH_QUOTE);
   assign cls.is_lf    = (cls_src == csvtok_pkg::CH_LF);
   assign cls.is_cr    = (cls_src == csvtok_pkg::CH_CR);
   assign cls.is_ws    = (cls_src == csvtok_pkg::CH_SPACE) ||
                         (cls_src == csvtok_pkg::CH_TAB);

   // common decode terms
   assign hcnt        = (mode_ff == csvtok_pkg::M_LINE) ? '0 : cnt_ff;
   assign bom_hit     = (mode_ff == csvtok_pkg::M_LINE) && !row_seen_ff &&
                        (byte_ff == csvtok_pkg::bom_byte(bom_ff));
   assign bom_last    = ((idx_ff + csvtok_pkg::cnt_type'(1)) ==
                         csvtok_pkg::cnt_type'(bom_ff));
   assign replay_last = ((idx_ff + csvtok_pkg::cnt_type'(1)) == cnt_ff);

   // held whitespace store
   csvtok_ram #(
      .WIDTH (8),
      .DEPTH (csvtok_pkg::HOLD_DEPTH)
   ) u_hold_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (hcnt[csvtok_pkg::HOLD_AW-1:0]),
      .wr_data (byte_ff),
      .rd_addr (advance ? idx_in[csvtok_pkg::HOLD_AW-1:0]
                        : idx_ff[csvtok_pkg::HOLD_AW-1:0]),
      .rd_data (rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csvtok_pkg::S_IDLE: begin
            if (accept) state_in = csvtok_pkg::S_DECIDE;
         end
         csvtok_pkg::S_DECIDE: begin
            priority if (err_ff) begin
               state_in = csvtok_pkg::S_FIN;
            end else if (cr_ff && cls.is_lf) begin
               state_in = csvtok_pkg::S_FIN;
            end else if (bom_hit) begin
               state_in = csvtok_pkg::S_FIN;
            end else if (mode_ff == csvtok_pkg::M_LINE && bom_ff != 2'd0) begin
               state_in = csvtok_pkg::S_BOM;
            end else if (mode_ff == csvtok_pkg::M_LINE ||
                         mode_ff == csvtok_pkg::M_HOLD) begin
               priority if (cls.is_ws || cls.is_lf || cls.is_cr) begin
                  state_in = csvtok_pkg::S_FIN;
               end else if (hcnt != '0) begin
                  state_in = csvtok_pkg::S_REPLAY;
               end else begin
                  state_in = csvtok_pkg::S_ROW;
               end
            end else begin
               state_in = csvtok_pkg::S_ROW;
            end
         end
         csvtok_pkg::S_BOM: begin
            if (bom_last) begin
               state_in = in_fin_ff ? csvtok_pkg::S_ENDROW : csvtok_pkg::S_ROW;
            end
         end
         csvtok_pkg::S_REPLAY: begin
            if (replay_last) begin
               state_in = in_fin_ff ? csvtok_pkg::S_ENDROW : csvtok_pkg::S_ROW;
            end
         end
         csvtok_pkg::S_ROW: begin
            state_in = csvtok_pkg::S_FIN;
         end
         csvtok_pkg::S_FIN: begin
            state_in = csvtok_pkg::S_DONE;
            if (fin_ff && !err_ff) begin
               case (mode_ff)
                  csvtok_pkg::M_LINE: begin
                     if (bom_ff != 2'd0) state_in = csvtok_pkg::S_BOM;
                  end
                  csvtok_pkg::M_HOLD: begin
                     if (cnt_ff != '0) state_in = csvtok_pkg::S_REPLAY;
                  end
                  csvtok_pkg::M_FSTART,
                  csvtok_pkg::M_PLAIN,
                  csvtok_pkg::M_QSEEN,
                  csvtok_pkg::M_AFTERQ: begin
                     state_in = csvtok_pkg::S_ENDROW;
                  end
                  default: state_in = csvtok_pkg::S_DONE;
               endcase
            end
         end
         csvtok_pkg::S_ENDROW: begin
            state_in = csvtok_pkg::S_DONE;
         end
         csvtok_pkg::S_DONE: begin
            state_in = csvtok_pkg::S_IDLE;
         end
         default: state_in = csvtok_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs and parser state updates
   always_comb begin
      mode_in     = mode_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      bom_in      = bom_ff;
      cr_in       = cr_ff;
      row_seen_in = row_seen_ff;
      err_in      = err_ff;
      in_fin_in   = in_fin_ff;
      emit_valid  = 1'b0;
      emit_kind   = csvtok_pkg::K_CONTENT;
      emit_byte   = 8'h00;
      wr_en       = 1'b0;
      unique case (state_ff)
         csvtok_pkg::S_IDLE: begin
            in_fin_in = 1'b0;
         end
         csvtok_pkg::S_DECIDE: begin
            idx_in = '0;
            if (!err_ff) begin
               cr_in = 1'b0;
               priority if (cr_ff && cls.is_lf) begin
                  cr_in = 1'b0;
               end else if (bom_hit) begin
                  if (bom_ff == 2'd2) begin
                     bom_in  = 2'd0;
                     cnt_in  = '0;
                     mode_in = csvtok_pkg::M_HOLD;
                  end else begin
                     bom_in = bom_ff + 2'd1;
                  end
               end else if (mode_ff == csvtok_pkg::M_LINE && bom_ff != 2'd0) begin
                  // broken bom: matched bytes go out as plain content
                  mode_in = csvtok_pkg::M_PLAIN;
               end else if (mode_ff == csvtok_pkg::M_LINE ||
                            mode_ff == csvtok_pkg::M_HOLD) begin
                  priority if (cls.is_ws) begin
                     mode_in = csvtok_pkg::M_HOLD;
                     if (hcnt < csvtok_pkg::cnt_type'(csvtok_pkg::HOLD_DEPTH)) begin
                        wr_en  = advance;
                        cnt_in = hcnt + csvtok_pkg::cnt_type'(1);
                     end else begin
                        cnt_in     = hcnt;
                        emit_valid = 1'b1;
                        emit_kind  = csvtok_pkg::K_OVER;
                     end
                  end else if (cls.is_lf || cls.is_cr) begin
                     cnt_in  = '0;
                     mode_in = csvtok_pkg::M_LINE;
                     cr_in   = cls.is_cr;
                  end else begin
                     cnt_in  = hcnt;
                     mode_in = csvtok_pkg::M_FSTART;
                  end
               end else begin
                  mode_in = mode_ff;
               end
            end
         end
         csvtok_pkg::S_BOM: begin
            emit_valid = 1'b1;
            emit_kind  = csvtok_pkg::K_CONTENT;
            emit_byte  = csvtok_pkg::bom_byte(idx_ff[1:0]);
            idx_in     = idx_ff + csvtok_pkg::cnt_type'(1);
            if (bom_last) begin
               bom_in = 2'd0;
               idx_in = '0;
            end
         end
         csvtok_pkg::S_REPLAY: begin
            emit_valid = 1'b1;
            idx_in     = idx_ff + csvtok_pkg::cnt_type'(1);
            if (cls.is_sep) begin
               emit_kind = csvtok_pkg::K_FIELD;
               mode_in   = csvtok_pkg::M_FSTART;
            end else begin
               emit_kind = csvtok_pkg::K_CONTENT;
               emit_byte = rd_data;
               mode_in   = csvtok_pkg::M_PLAIN;
            end
            if (replay_last) begin
               cnt_in = '0;
            end
         end
         csvtok_pkg::S_ROW: begin
            priority if (mode_ff == csvtok_pkg::M_FSTART && cls.is_quote) begin
               mode_in = csvtok_pkg::M_QUOTED;
            end else if (mode_ff == csvtok_pkg::M_QUOTED) begin
               if (cls.is_quote) begin
                  mode_in = csvtok_pkg::M_QSEEN;
               end else begin
                  emit_valid = 1'b1;
                  emit_byte  = byte_ff;
               end
            end else if (mode_ff == csvtok_pkg::M_QSEEN && cls.is_quote) begin
               // doubled quote inside a quoted field
               emit_valid = 1'b1;
               emit_byte  = csvtok_pkg::CH_QUOTE;
               mode_in    = csvtok_pkg::M_QUOTED;
            end else if (cls.is_sep) begin
               emit_valid = 1'b1;
               emit_kind  = csvtok_pkg::K_FIELD;
               mode_in    = csvtok_pkg::M_FSTART;
            end else if (cls.is_lf || cls.is_cr) begin
               emit_valid  = 1'b1;
               emit_kind   = csvtok_pkg::K_ROW;
               mode_in     = csvtok_pkg::M_LINE;
               row_seen_in = 1'b1;
               cr_in       = cls.is_cr;
            end else if (mode_ff == csvtok_pkg::M_FSTART ||
                         mode_ff == csvtok_pkg::M_PLAIN) begin
               emit_valid = 1'b1;
               emit_byte  = byte_ff;
               mode_in    = csvtok_pkg::M_PLAIN;
            end else if (cls.is_ws) begin
               mode_in = csvtok_pkg::M_AFTERQ;
            end else begin
               // junk after a closing quote
               emit_valid = 1'b1;
               emit_kind  = csvtok_pkg::K_BADQ;
               err_in     = 1'b1;
            end
         end
         csvtok_pkg::S_FIN: begin
            if (fin_ff && !err_ff) begin
               idx_in    = '0;
               in_fin_in = 1'b1;
               case (mode_ff)
                  csvtok_pkg::M_HOLD: begin
                     if (cnt_ff != '0) mode_in = csvtok_pkg::M_FSTART;
                  end
                  csvtok_pkg::M_QUOTED: begin
                     emit_valid = 1'b1;
                     emit_kind  = csvtok_pkg::K_UNTERM;
                     err_in     = 1'b1;
                  end
                  default: mode_in = mode_ff;
               endcase
            end
         end
         csvtok_pkg::S_ENDROW: begin
            emit_valid = 1'b1;
            emit_kind  = csvtok_pkg::K_ROW;
         end
         csvtok_pkg::S_DONE: begin
            if (fin_ff) begin
               mode_in     = csvtok_pkg::M_LINE;
               cnt_in      = '0;
               idx_in      = '0;
               bom_in      = 2'd0;
               cr_in       = 1'b0;
               row_seen_in = 1'b0;
               err_in      = 1'b0;
            end
         end
         default: mode_in = mode_ff;
      endcase
   end

   // pending result moves to the output when the next one forms or at retire
   assign push = advance && pend_valid_ff &&
                 (emit_valid || state_ff == csvtok_pkg::S_DONE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= csvtok_pkg::S_IDLE;
         mode_ff       <= csvtok_pkg::M_LINE;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         bom_ff        <= 2'd0;
         cr_ff         <= 1'b0;
         row_seen_ff   <= 1'b0;
         err_ff        <= 1'b0;
         in_fin_ff     <= 1'b0;
         sep_ff        <= csvtok_pkg::SEP_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            sep_ff <= csr_field_separator;
         end
         if (advance) begin
            state_ff    <= state_in;
            mode_ff     <= mode_in;
            cnt_ff      <= cnt_in;
            idx_ff      <= idx_in;
            bom_ff      <= bom_in;
            cr_ff       <= cr_in;
            row_seen_ff <= row_seen_in;
            err_ff      <= err_in;
            in_fin_ff   <= in_fin_in;
            if (emit_valid) begin
               pend_valid_ff <= 1'b1;
            end else if (state_ff == csvtok_pkg::S_DONE) begin
               pend_valid_ff <= 1'b0;
            end
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_data.text_byte;
         fin_ff  <= req_data.final_byte;
      end
      if (advance && emit_valid) begin
         pend_kind_ff <= emit_kind;
         pend_byte_ff <= emit_byte;
      end
      if (push) begin
         rsp_ff.out_kind    <= pend_kind_ff;
         rsp_ff.out_byte    <= pend_byte_ff;
         rsp_ff.last_of_run <= (state_ff == csvtok_pkg::S_DONE);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= csvtok_pkg::cnt_type'(csvtok_pkg::HOLD_DEPTH))
      else $error("held whitespace count beyond buffer depth");

   a_bom_range: assert property (@(posedge clock) disable iff (reset)
      bom_ff != 2'd3)
      else $error("bom match count out of range");

   a_replay_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == csvtok_pkg::S_REPLAY |-> cnt_ff != '0)
      else $error("replay with empty whitespace buffer");

   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      accept |-> !pend_valid_ff)
      else $error("byte accepted with a result still pending");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == csvtok_pkg::S_DONE && fin_ff && advance) |=>
      (mode_ff == csvtok_pkg::M_LINE && cnt_ff == '0 && !err_ff && !row_seen_ff))
      else $error("parser state not cleared after final byte");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for csv_byte_tokenizer
// Streams generated csv texts through the byte channel and predicts every
// token from an in-bench parser. Texts are mostly well formed: rows, quoted
// fields with escapes, leading whitespace, blank lines, byte order marks,
// line endings of every kind. They are salted with noise bytes, broken
// quotes and whitespace runs that overflow the hold buffer. The separator is
// changed between phases, extremes included. Both channels idle at random,
// and the token side holds off once for a long stretch.
// ----------------------------------------------------------------------------
import csvtok_pkg::*;

// predicts the token stream and checks tokens in order
class csv_token_board;
   logic [7:0] sep;
   mode_type   mode;
   logic [7:0] held [HOLD_DEPTH];
   int         held_n;
   int         bom_n;
   bit         cr_pend;
   bit         row_seen;
   bit         err_latched;
   logic [7:0] bom_seq [3];
   rsp_type    step_tokens [$];
   rsp_type    due_tokens [$];
   int         mismatches;
   int         tokens_checked;
   int         kind_count [6];

   function new();
      bom_seq[0] = BOM_B0;
      bom_seq[1] = BOM_B1;
      bom_seq[2] = BOM_B2;
      sep = SEP_RESET;
      mismatches = 0;
      tokens_checked = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
      clear_parse();
   endfunction

   function void clear_parse();
      mode = M_LINE;
      held_n = 0;
      bom_n = 0;
      cr_pend = 1'b0;
      row_seen = 1'b0;
      err_latched = 1'b0;
   endfunction

   // one token of the current byte, capped at 36 tokens
   function void emit(out_kind_type k, logic [7:0] b);
      rsp_type r;
      r.out_kind = k;
      r.out_byte = (k == K_CONTENT) ? b : 8'h00;
      r.last_of_run = 1'b0;
      if (step_tokens.size() < 36) step_tokens.push_back(r);
   endfunction

   function void end_row(bit by_cr);
      emit(K_ROW, 8'h00);
      mode = M_LINE;
      row_seen = 1'b1;
      cr_pend = by_cr;
   endfunction

   function void plain_byte(logic [7:0] c);
      if (c == sep) begin
         emit(K_FIELD, 8'h00);
         mode = M_FSTART;
      end else if (c == CH_LF) begin
         end_row(1'b0);
      end else if (c == CH_CR) begin
         end_row(1'b1);
      end else begin
         emit(K_CONTENT, c);
         mode = M_PLAIN;
      end
   endfunction

   // after a closing quote only separator, line end or whitespace is legal
   function void after_quote_byte(logic [7:0] c);
      if (c == sep) begin
         emit(K_FIELD, 8'h00);
         mode = M_FSTART;
      end else if (c == CH_LF) begin
         end_row(1'b0);
      end else if (c == CH_CR) begin
         end_row(1'b1);
      end else if (c == CH_SPACE || c == CH_TAB) begin
         mode = M_AFTERQ;
      end else begin
         emit(K_BADQ, 8'h00);
         err_latched = 1'b1;
      end
   endfunction

   function void row_byte(logic [7:0] c);
      case (mode)
         M_FSTART: begin
            if (c == CH_QUOTE) mode = M_QUOTED;
            else plain_byte(c);
         end
         M_PLAIN: plain_byte(c);
         M_QUOTED: begin
            if (c == CH_QUOTE) mode = M_QSEEN;
            else emit(K_CONTENT, c);
         end
         M_QSEEN: begin
            if (c == CH_QUOTE) begin
               emit(K_CONTENT, CH_QUOTE);
               mode = M_QUOTED;
            end else begin
               after_quote_byte(c);
            end
         end
         default: after_quote_byte(c);
      endcase
   endfunction

   // held whitespace comes out in order, separators included
   function void replay_held();
      mode = M_FSTART;
      for (int i = 0; i < held_n; i++) begin
         if (held[i] == sep) begin
            emit(K_FIELD, 8'h00);
            mode = M_FSTART;
         end else begin
            emit(K_CONTENT, held[i]);
            mode = M_PLAIN;
         end
      end
      held_n = 0;
   endfunction

   function void release_bom();
      for (int i = 0; i < bom_n; i++) emit(K_CONTENT, bom_seq[i]);
      bom_n = 0;
   endfunction

   function void hold_byte(logic [7:0] c);
      if (c == CH_SPACE || c == CH_TAB) begin
         if (held_n < HOLD_DEPTH) begin
            held[held_n] = c;
            held_n++;
         end else begin
            emit(K_OVER, 8'h00);
         end
      end else if (c == CH_LF || c == CH_CR) begin
         // whitespace-only line is skipped
         held_n = 0;
         mode = M_LINE;
         cr_pend = (c == CH_CR);
      end else begin
         replay_held();
         row_byte(c);
      end
   endfunction

   function void line_byte(logic [7:0] c);
      if (bom_n > 2) bom_n = 0;
      if (!row_seen && c == bom_seq[bom_n]) begin
         bom_n++;
         if (bom_n == 3) begin
            bom_n = 0;
            held_n = 0;
            mode = M_HOLD;
         end
      end else if (bom_n > 0) begin
         // broken byte order mark turns into field content
         release_bom();
         mode = M_PLAIN;
         plain_byte(c);
      end else begin
         held_n = 0;
         mode = M_HOLD;
         hold_byte(c);
      end
   endfunction

   function void finish_text();
      if (!err_latched) begin
         case (mode)
            M_LINE: begin
               if (bom_n > 0) begin
                  release_bom();
                  emit(K_ROW, 8'h00);
               end
            end
            M_HOLD: begin
               if (held_n > 0) begin
                  replay_held();
                  emit(K_ROW, 8'h00);
               end
            end
            M_QUOTED: begin
               emit(K_UNTERM, 8'h00);
               err_latched = 1'b1;
            end
            default: emit(K_ROW, 8'h00);
         endcase
      end
   endfunction

   // accepted byte: queue the tokens it causes
   function void note_byte(req_type d);
      logic [7:0] c;
      rsp_type    r;
      c = d.text_byte;
      step_tokens.delete();
      if (!err_latched) begin
         if (cr_pend && c == CH_LF) begin
            cr_pend = 1'b0;
         end else begin
            cr_pend = 1'b0;
            if (mode == M_LINE) line_byte(c);
            else if (mode == M_HOLD) hold_byte(c);
            else row_byte(c);
         end
      end
      if (d.final_byte) begin
         finish_text();
         clear_parse();
      end
      foreach (step_tokens[i]) begin
         r = step_tokens[i];
         r.last_of_run = (i == step_tokens.size() - 1);
         due_tokens.push_back(r);
      end
   endfunction

   // accepted token against the oldest prediction
   function void check_token(rsp_type got);
      rsp_type want;
      if (got.out_kind <= K_OVER) kind_count[got.out_kind]++;
      if (due_tokens.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tb: token with nothing expected: kind %0d byte %02h last %0b",
                     got.out_kind, got.out_byte, got.last_of_run);
      end else begin
         want = due_tokens.pop_front();
         if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
             got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: token %0d expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                        tokens_checked, want.out_kind, want.out_byte, want.last_of_run,
                        got.out_kind, got.out_byte, got.last_of_run);
         end
      end
      tokens_checked++;
   endfunction
endclass

module tb;

   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_BYTES   = 40;
   localparam longint LIMIT     = 200000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [7:0] csr_field_separator;

   csv_token_board sb;
   req_type text_q [$];
   int      bytes_sent;
   int      texts_sent;
   int      seps_used;
   bit      quiet;
   int      hold_asked;
   int      hold_taken;
   int      hold_left;
   longint  cycles;

   csv_byte_tokenizer u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data            (rsp_data),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_field_separator (csr_field_separator)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb: timeout after %0d cycles", cycles);
         $display("tb: errors");
         $finish;
      end
   end

   // token side: check each transfer, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_token(rsp_data);
      if (hold_asked != hold_taken) begin
         hold_taken = hold_asked;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 20);
      end
   end

   // text building
   function automatic void add_byte(logic [7:0] b);
      req_type r;
      r.text_byte = b;
      r.final_byte = 1'b0;
      text_q.push_back(r);
   endfunction

   function automatic void end_text();
      req_type r;
      if (text_q.size() == 0) add_byte($urandom_range(8'h7E, 8'h21));
      r = text_q.pop_back();
      r.final_byte = 1'b1;
      text_q.push_back(r);
   endfunction

   function automatic void add_space();
      add_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
   endfunction

   function automatic void add_line_end();
      case ($urandom_range(2))
         0: add_byte(CH_LF);
         1: add_byte(CH_CR);
         default: begin
            add_byte(CH_CR);
            add_byte(CH_LF);
         end
      endcase
   endfunction

   function automatic void add_field();
      int n;
      int pick;
      logic [7:0] b;
      if ($urandom_range(99) < 20)
         for (int i = $urandom_range(1, 3); i > 0; i--) add_space();
      pick = $urandom_range(9);
      if (pick >= 2 && pick <= 5) begin
         // unquoted, with the odd noise byte
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            if ($urandom_range(99) < 8) add_byte($urandom_range(255));
            else add_byte($urandom_range(8'h7E, 8'h21));
      end else if (pick >= 6) begin
         // quoted, with escaped quotes and any byte inside
         add_byte(CH_QUOTE);
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 10) begin
               add_byte(CH_QUOTE);
               add_byte(CH_QUOTE);
            end else begin
               b = $urandom_range(255);
               add_byte((b == CH_QUOTE) ? 8'h51 : b);
            end
         end
         add_byte(CH_QUOTE);
         if ($urandom_range(99) < 30)
            for (int i = $urandom_range(1, 2); i > 0; i--) add_space();
      end
   endfunction

   function automatic void build_text(bit long_ws);
      int rows;
      int fields;
      rows = $urandom_range(1, 4);
      if ($urandom_range(99) < 20) begin
         add_byte(BOM_B0);
         add_byte(BOM_B1);
         add_byte(BOM_B2);
      end else if ($urandom_range(99) < 8) begin
         // partial mark
         add_byte(BOM_B0);
         if ($urandom_range(1)) add_byte(BOM_B1);
      end
      for (int r = 0; r < rows; r++) begin
         if ($urandom_range(99) < 15) begin
            for (int i = $urandom_range(0, 3); i > 0; i--) add_space();
            add_line_end();
         end
         if ((long_ws && r == 0) || $urandom_range(99) < 3)
            for (int i = $urandom_range(28, 36); i > 0; i--) add_space();
         fields = $urandom_range(1, 4);
         for (int f = 0; f < fields; f++) begin
            if (f > 0) add_byte(sb.sep);
            add_field();
         end
         if (r < rows - 1 || $urandom_range(1)) add_line_end();
      end
      // broken tail: unterminated quote or junk after a closing quote
      if ($urandom_range(99) < 6) begin
         add_byte(CH_QUOTE);
         add_byte($urandom_range(8'h7E, 8'h23));
         if ($urandom_range(1)) begin
            add_byte(CH_QUOTE);
            add_byte(8'h78);
            add_byte(8'h79);
         end
      end
      end_text();
   endfunction

   // byte channel: random idle cycles, then one transfer
   task automatic offer_byte(req_type d);
      while (!quiet && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_byte(d);
      bytes_sent++;
   endtask

   task automatic send_text();
      while (text_q.size() > 0) offer_byte(text_q.pop_front());
      texts_sent++;
   endtask

   // wait for every token, then for the block to go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.due_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_separator(logic [7:0] s);
      csr_valid <= 1'b1;
      csr_field_separator <= s;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      sb.sep = s;
      seps_used++;
   endtask

   task automatic random_texts(int n);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n) begin
         build_text(1'b0);
         send_text();
      end
   endtask

   task automatic phase(logic [7:0] s);
      drain();
      write_separator(s);
      random_texts(PHASE_BYTES);
   endtask

   initial begin
      int fails;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_field_separator <= SEP_RESET;
      bytes_sent = 0;
      texts_sent = 0;
      seps_used = 1;
      quiet = 1'b0;
      hold_asked = 0;
      hold_taken = 0;
      hold_left = 0;
      cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // mark dropped, held whitespace released, escaped quote, crlf
      add_byte(BOM_B0);
      add_byte(BOM_B1);
      add_byte(BOM_B2);
      add_byte(CH_SPACE);
      add_byte(CH_TAB);
      add_byte("a");
      add_byte(SEP_RESET);
      add_byte(CH_QUOTE);
      add_byte("x");
      add_byte(CH_QUOTE);
      add_byte(CH_QUOTE);
      add_byte(CH_QUOTE);
      add_byte(CH_SPACE);
      add_byte(CH_CR);
      add_byte(CH_LF);
      // junk after closing quote, then ignored up to the last byte
      add_byte(CH_QUOTE);
      add_byte("q");
      add_byte(CH_QUOTE);
      add_byte("z");
      add_byte("k");
      end_text();
      send_text();
      // quote left open at the end
      add_byte(CH_QUOTE);
      add_byte(8'hFF);
      end_text();
      send_text();
      // mark broken after one byte
      add_byte(BOM_B0);
      add_byte(8'h00);
      end_text();
      send_text();
      // whitespace alone at the end
      add_byte(CH_SPACE);
      add_byte(CH_TAB);
      end_text();
      send_text();

      // default separator: whitespace run that can overflow, then a mid-phase pause
      build_text(1'b1);
      send_text();
      random_texts(PHASE_BYTES / 2);
      drain();
      random_texts(PHASE_BYTES / 2);

      // semicolon, with one long hold-off on the token side
      drain();
      write_separator(8'h3B);
      hold_asked++;
      random_texts(PHASE_BYTES);

      phase(8'h00);
      quiet = 1'b1;
      phase(8'hFF);
      quiet = 1'b0;
      phase(CH_TAB);
      phase(CH_SPACE);
      phase(CH_QUOTE);
      phase(SEP_RESET);

      drain();
      fails = sb.mismatches + sb.due_tokens.size();
      $display("tb: %0d bytes in %0d texts, %0d separator settings, %0d tokens checked",
               bytes_sent, texts_sent, seps_used, sb.tokens_checked);
      $display("tb: tokens by kind: content %0d field %0d row %0d badq %0d unterm %0d over %0d",
               sb.kind_count[0], sb.kind_count[1], sb.kind_count[2],
               sb.kind_count[3], sb.kind_count[4], sb.kind_count[5]);
      if (fails == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: %0d mismatches", fails);
         $display("tb: errors");
      end
      $finish;
   end

endmodule
